### hw/rtl/dtcc_pkg.sv
// Shared constants and controller/datapath interface types for the cross-correlator.
package dtcc_pkg;

  localparam int MagW     = 16;
  localparam int LenW     = 13;
  localparam int OffW     = 15;
  localparam int HistAw   = 15;
  localparam int TmplAw   = 12;
  localparam int CntW     = 40;
  localparam int LagW     = 41;
  localparam int SumW     = 28;
  localparam int SqW      = 44;
  localparam int SqHalfW  = 22;
  localparam int DevW     = 28;
  localparam int NormW    = 56;
  localparam int AccW     = 60;
  localparam int RemW     = 61;
  localparam int QW       = 15;
  localparam int StepW    = 6;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 15;

  localparam logic [LenW-1:0] MaxTemplate = 13'd4096;
  localparam logic [OffW-1:0] MaxOffset   = 15'd16384;
  localparam logic [LenW-1:0] LenReset    = 13'd256;
  localparam logic [OffW-1:0] OffReset    = 15'd8192;

  localparam logic [CfgIdxW-1:0] RegLen = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOff = 2'd1;

  localparam logic [StepW-1:0] MagSteps  = 6'd16;
  localparam logic [StepW-1:0] SqrtSteps = 6'd28;
  localparam logic [StepW-1:0] DivSteps  = 6'd15;

  typedef struct packed {
    logic load;
    logic mag_step;
    logic capture;
    logic dev_mul1;
    logic dev_mul2;
    logic dev_rad;
    logic sqrt_step;
    logic norm;
    logic dot_start;
    logic dot_run;
    logic div_init;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic mag_done;
    logic last_cap;
    logic tmpl_ready;
    logic sqrt_done;
    logic dot_done;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

### hw/rtl/dual_template_cross_correlator.sv
// Top level of the dual-template cross-correlator with peak search.
// Input channel: in_valid/in_ready with one IQ byte pair per receiver (A and B).
// Each transfer forms two magnitudes, stores them in the history stores and,
// at samples template_offset .. template_offset+template_length-1, in the
// template stores. Once the last template sample is in, every transfer yields
// one result on out_valid/out_ready: the lag relative to the offset, both
// normalized correlations in Q3.12 and the running positive peaks with lags.
// Before that no result is produced.
// Per transfer: while templates are filling, the block is busy until the
// magnitudes are captured, and it takes no new transfer meanwhile. Once
// correlating, the result is registered after the correlation and the divide,
// and in_ready returns as it is loaded (two MACs per template sample, one per
// correlation, on a pipelined datapath, plus a 15-step divider); the last template
// sample also runs the deviation square root first.
// The block takes one item at a time; in_ready is high only when idle.
// A finished result waits in the output register while the receiver stalls;
// the next item is taken meanwhile but its result is held back until then.
// Config: cfg_valid/cfg_ready, always ready; writing register 0 or 1 restarts
// the block. Reset (rst, synchronous) restores the register defaults and clears the
// sample counters, sums, peaks and control state; the stores are not cleared, and no clearing pass is needed.
module dual_template_cross_correlator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dtcc_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [dtcc_pkg::CfgDataW-1:0]        cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_phase_a,
  input  logic [7:0]                           quadrature_a,
  input  logic [7:0]                           in_phase_b,
  input  logic [7:0]                           quadrature_b,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [dtcc_pkg::LagW-1:0]     lag_from_offset,
  output logic signed [15:0]                   corr_a_on_b,
  output logic signed [15:0]                   corr_b_on_a,
  output logic [14:0]                          peak_a_on_b,
  output logic signed [dtcc_pkg::LagW-1:0]     peak_a_on_b_lag,
  output logic [14:0]                          peak_b_on_a,
  output logic signed [dtcc_pkg::LagW-1:0]     peak_b_on_a_lag
);

  dtcc_pkg::cmd_t  cmd;
  dtcc_pkg::stat_t st;
  logic clear;

  assign cfg_ready = 1'b1;
  assign clear = rst || (cfg_valid &&
                 (cfg_index == dtcc_pkg::RegLen || cfg_index == dtcc_pkg::RegOff));

  dtcc_ctrl u_ctrl (
    .clk      (clk),
    .clear    (clear),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .st       (st)
  );

  dtcc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .clear           (clear),
    .cfg_wr          (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_phase_a      (in_phase_a),
    .quadrature_a    (quadrature_a),
    .in_phase_b      (in_phase_b),
    .quadrature_b    (quadrature_b),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .lag_from_offset (lag_from_offset),
    .corr_a_on_b     (corr_a_on_b),
    .corr_b_on_a     (corr_b_on_a),
    .peak_a_on_b     (peak_a_on_b),
    .peak_a_on_b_lag (peak_a_on_b_lag),
    .peak_b_on_a     (peak_b_on_a),
    .peak_b_on_a_lag (peak_b_on_a_lag)
  );

endmodule

### hw/rtl/dtcc_ctrl.sv
// Sequencer that steps one input transfer through magnitude, capture, statistics,
// correlation and normalization.
module dtcc_ctrl (
  input  logic           clk,
  input  logic           clear,
  input  logic           in_valid,
  output logic           in_ready,
  output dtcc_pkg::cmd_t cmd,
  input  dtcc_pkg::stat_t st
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MAG    = 4'd1;
  localparam logic [3:0] S_CAPT   = 4'd2;
  localparam logic [3:0] S_CHK    = 4'd3;
  localparam logic [3:0] S_DEV1   = 4'd4;
  localparam logic [3:0] S_DEV2   = 4'd5;
  localparam logic [3:0] S_DEV3   = 4'd6;
  localparam logic [3:0] S_SQRT   = 4'd7;
  localparam logic [3:0] S_NORM   = 4'd8;
  localparam logic [3:0] S_DSTART = 4'd9;
  localparam logic [3:0] S_DOT    = 4'd10;
  localparam logic [3:0] S_DINIT  = 4'd11;
  localparam logic [3:0] S_DIV    = 4'd12;
  localparam logic [3:0] S_FIN    = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_MAG;
        end
      end
      S_MAG: begin
        if (st.mag_done) state_next = S_CAPT;
        else cmd.mag_step = 1'b1;
      end
      S_CAPT: begin
        cmd.capture = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (st.last_cap) state_next = S_DEV1;
        else if (st.tmpl_ready) state_next = S_DSTART;
        else state_next = S_IDLE;
      end
      S_DEV1: begin
        cmd.dev_mul1 = 1'b1;
        state_next = S_DEV2;
      end
      S_DEV2: begin
        cmd.dev_mul2 = 1'b1;
        state_next = S_DEV3;
      end
      S_DEV3: begin
        cmd.dev_rad = 1'b1;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        if (st.sqrt_done) state_next = S_NORM;
        else cmd.sqrt_step = 1'b1;
      end
      S_NORM: begin
        cmd.norm = 1'b1;
        state_next = S_DSTART;
      end
      S_DSTART: begin
        cmd.dot_start = 1'b1;
        state_next = S_DOT;
      end
      S_DOT: begin
        cmd.dot_run = 1'b1;
        if (st.dot_done) state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (st.div_done) state_next = S_FIN;
        else cmd.div_step = 1'b1;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (clear) state <= S_IDLE;
    else state <= state_next;
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (clear)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_finish_free: assert property (@(posedge clk) disable iff (clear)
    cmd.finish |-> st.out_free)
    else $error("result loaded over an untaken result");

  a_sqrt_bound: assert property (@(posedge clk) disable iff (clear)
    cmd.sqrt_step |-> !st.sqrt_done)
    else $error("square root stepped past its end");

  a_dot_ready: assert property (@(posedge clk) disable iff (clear)
    cmd.dot_start |-> st.tmpl_ready)
    else $error("correlation started without templates");

endmodule

### hw/rtl/dtcc_dp.sv
// Datapath: magnitude root, history and template stores, statistics, MAC and divider.
module dtcc_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 clear,
  input  logic                                 cfg_wr,
  input  logic [dtcc_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [dtcc_pkg::CfgDataW-1:0]        cfg_data,
  input  logic [7:0]                           in_phase_a,
  input  logic [7:0]                           quadrature_a,
  input  logic [7:0]                           in_phase_b,
  input  logic [7:0]                           quadrature_b,
  input  dtcc_pkg::cmd_t                       cmd,
  output dtcc_pkg::stat_t                      st,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [dtcc_pkg::LagW-1:0]     lag_from_offset,
  output logic signed [15:0]                   corr_a_on_b,
  output logic signed [15:0]                   corr_b_on_a,
  output logic [14:0]                          peak_a_on_b,
  output logic signed [dtcc_pkg::LagW-1:0]     peak_a_on_b_lag,
  output logic [14:0]                          peak_b_on_a,
  output logic signed [dtcc_pkg::LagW-1:0]     peak_b_on_a_lag
);

  logic [dtcc_pkg::LenW-1:0] len_reg, eff_len;
  logic [dtcc_pkg::OffW-1:0] off_reg, eff_off;

  logic [31:0] mva, mra, mvb, mrb, mbit;
  logic [dtcc_pkg::StepW-1:0] step;

  logic [dtcc_pkg::HistAw-1:0] hist_pos, rd_idx;
  logic [dtcc_pkg::CntW-1:0] sample_count, t_cur, cap_diff;
  logic cap_hit, last_cap, tmpl_ready;
  logic [dtcc_pkg::SumW-1:0] sum_a, sum_b;
  logic [dtcc_pkg::SqW-1:0] sq_a, sq_b;

  logic [34:0] m1_a, m1_b, m2_a, m2_b;
  logic [dtcc_pkg::NormW-1:0] sqs_a, sqs_b;
  logic [dtcc_pkg::NormW-1:0] dva, dra, dvb, drb, dbit;
  logic [dtcc_pkg::NormW-1:0] norm;

  logic [dtcc_pkg::LenW-1:0] kk;
  logic v0, v1, v2;
  logic [dtcc_pkg::MagW-1:0] tdat_a, tdat_b, hdat_a, hdat_b, h1_a, h1_b;
  logic [28:0] lt_a, lt_b;
  logic signed [46:0] prod_a, prod_b;
  logic signed [dtcc_pkg::AccW-1:0] acc_a, acc_b;

  logic [dtcc_pkg::RemW-1:0] rem_a, rem_b, den4;
  logic [dtcc_pkg::QW-1:0] q_a, q_b;
  logic neg_a, neg_b, sat_a, sat_b;
  logic signed [15:0] cab, cba;
  logic [dtcc_pkg::CntW-1:0] p40;
  logic [dtcc_pkg::LagW-1:0] lag;

  logic [dtcc_pkg::MagW-1:0] hist_a_mem [2**dtcc_pkg::HistAw];
  logic [dtcc_pkg::MagW-1:0] hist_b_mem [2**dtcc_pkg::HistAw];
  logic [dtcc_pkg::MagW-1:0] tmpl_a_mem [2**dtcc_pkg::TmplAw];
  logic [dtcc_pkg::MagW-1:0] tmpl_b_mem [2**dtcc_pkg::TmplAw];

  logic rd_en;

  function automatic logic [31:0] mag_rad(input logic [7:0] i, input logic [7:0] q);
    logic signed [9:0] di, dq;
    logic [17:0] s;
    di = $signed({1'b0, i, 1'b0}) - 10'sd255;
    dq = $signed({1'b0, q, 1'b0}) - 10'sd255;
    s = 18'(di * di) + 18'(dq * dq);
    return {s, 14'b0};
  endfunction

  function automatic logic [dtcc_pkg::AccW-1:0] abs_acc(input logic signed [dtcc_pkg::AccW-1:0] a);
    return a[dtcc_pkg::AccW-1] ? dtcc_pkg::AccW'(-a) : dtcc_pkg::AccW'(a);
  endfunction

  function automatic logic signed [15:0] to_q12(input logic neg, input logic sat,
                                              input logic [14:0] q, input logic zero);
    logic signed [15:0] r;
    if (zero) r = 16'sd0;
    else if (neg) r = sat ? -16'sd32768 : -$signed({1'b0, q});
    else r = sat ? 16'sd32767 : $signed({1'b0, q});
    return r;
  endfunction

  always_comb begin
    if (len_reg == '0) eff_len = 13'd1;
    else if (len_reg > dtcc_pkg::MaxTemplate) eff_len = dtcc_pkg::MaxTemplate;
    else eff_len = len_reg;
    eff_off = (off_reg > dtcc_pkg::MaxOffset) ? dtcc_pkg::MaxOffset : off_reg;
  end

  assign cap_diff = sample_count - dtcc_pkg::CntW'(eff_off);
  assign cap_hit  = !tmpl_ready && (sample_count >= dtcc_pkg::CntW'(eff_off)) &&
                    (cap_diff < dtcc_pkg::CntW'(eff_len));
  assign rd_en    = cmd.dot_run && (kk != eff_len);
  assign den4     = {3'b0, norm, 2'b0};

  assign cab = to_q12(neg_a, sat_a, q_a, norm == '0);
  assign cba = to_q12(neg_b, sat_b, q_b, norm == '0);
  assign p40 = t_cur - dtcc_pkg::CntW'(eff_off) - dtcc_pkg::CntW'(eff_len) + 40'd1;
  assign lag = {1'b0, p40} - dtcc_pkg::LagW'(eff_off);

  assign st.mag_done   = (step == dtcc_pkg::MagSteps);
  assign st.sqrt_done  = (step == dtcc_pkg::SqrtSteps);
  assign st.div_done   = (step == dtcc_pkg::DivSteps);
  assign st.last_cap   = last_cap;
  assign st.tmpl_ready = tmpl_ready;
  assign st.dot_done   = (kk == eff_len) && !v0 && !v1 && !v2;
  assign st.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg <= dtcc_pkg::LenReset;
      off_reg <= dtcc_pkg::OffReset;
    end else if (cfg_wr) begin
      case (cfg_index)
        dtcc_pkg::RegLen: len_reg <= cfg_data[dtcc_pkg::LenW-1:0];
        dtcc_pkg::RegOff: off_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hist_a_mem[hist_pos] <= mra[15:0];
      hist_b_mem[hist_pos] <= mrb[15:0];
    end
    if (rd_en) begin
      hdat_a <= hist_a_mem[rd_idx];
      hdat_b <= hist_b_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && cap_hit) begin
      tmpl_a_mem[cap_diff[dtcc_pkg::TmplAw-1:0]] <= mra[15:0];
      tmpl_b_mem[cap_diff[dtcc_pkg::TmplAw-1:0]] <= mrb[15:0];
    end
    if (rd_en) begin
      tdat_a <= tmpl_a_mem[kk[dtcc_pkg::TmplAw-1:0]];
      tdat_b <= tmpl_b_mem[kk[dtcc_pkg::TmplAw-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      hist_pos     <= '0;
      sample_count <= '0;
      sum_a        <= '0;
      sum_b        <= '0;
      sq_a         <= '0;
      sq_b         <= '0;
      norm         <= '0;
      tmpl_ready   <= 1'b0;
      last_cap     <= 1'b0;
      peak_a_on_b  <= '0;
      peak_b_on_a  <= '0;
      peak_a_on_b_lag <= '0;
      peak_b_on_a_lag <= '0;
      out_valid    <= 1'b0;
      step         <= '0;
      kk           <= '0;
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;

      if (cmd.load) begin
        mva  <= mag_rad(in_phase_a, quadrature_a);
        mvb  <= mag_rad(in_phase_b, quadrature_b);
        mra  <= '0;
        mrb  <= '0;
        mbit <= 32'h4000_0000;
        step <= '0;
      end
      if (cmd.mag_step) begin
        if (mva >= mra + mbit) begin
          mva <= mva - (mra + mbit);
          mra <= (mra >> 1) + mbit;
        end else begin
          mra <= mra >> 1;
        end
        if (mvb >= mrb + mbit) begin
          mvb <= mvb - (mrb + mbit);
          mrb <= (mrb >> 1) + mbit;
        end else begin
          mrb <= mrb >> 1;
        end
        mbit <= mbit >> 2;
        step <= step + 6'd1;
      end

      if (cmd.capture) begin
        hist_pos     <= hist_pos + 15'd1;
        t_cur        <= sample_count;
        sample_count <= sample_count + 40'd1;
        last_cap     <= cap_hit &&
                        (cap_diff[dtcc_pkg::LenW-1:0] == eff_len - 13'd1);
        if (cap_hit) begin
          sum_a <= sum_a + dtcc_pkg::SumW'(mra[15:0]);
          sum_b <= sum_b + dtcc_pkg::SumW'(mrb[15:0]);
          sq_a  <= sq_a + dtcc_pkg::SqW'(mra[15:0] * mra[15:0]);
          sq_b  <= sq_b + dtcc_pkg::SqW'(mrb[15:0] * mrb[15:0]);
        end
      end

      if (cmd.dev_mul1) begin
        m1_a  <= 35'(eff_len * sq_a[dtcc_pkg::SqHalfW-1:0]);
        m1_b  <= 35'(eff_len * sq_b[dtcc_pkg::SqHalfW-1:0]);
        sqs_a <= dtcc_pkg::NormW'(sum_a * sum_a);
        sqs_b <= dtcc_pkg::NormW'(sum_b * sum_b);
      end
      if (cmd.dev_mul2) begin
        m2_a <= 35'(eff_len * sq_a[dtcc_pkg::SqW-1:dtcc_pkg::SqHalfW]);
        m2_b <= 35'(eff_len * sq_b[dtcc_pkg::SqW-1:dtcc_pkg::SqHalfW]);
      end
      if (cmd.dev_rad) begin
        dva  <= dtcc_pkg::NormW'({m2_a, 22'b0}) + dtcc_pkg::NormW'(m1_a) - sqs_a;
        dvb  <= dtcc_pkg::NormW'({m2_b, 22'b0}) + dtcc_pkg::NormW'(m1_b) - sqs_b;
        dra  <= '0;
        drb  <= '0;
        dbit <= dtcc_pkg::NormW'(1) << 54;
        step <= '0;
      end
      if (cmd.sqrt_step) begin
        if (dva >= dra + dbit) begin
          dva <= dva - (dra + dbit);
          dra <= (dra >> 1) + dbit;
        end else begin
          dra <= dra >> 1;
        end
        if (dvb >= drb + dbit) begin
          dvb <= dvb - (drb + dbit);
          drb <= (drb >> 1) + dbit;
        end else begin
          drb <= drb >> 1;
        end
        dbit <= dbit >> 2;
        step <= step + 6'd1;
      end
      if (cmd.norm) begin
        norm       <= dra[dtcc_pkg::DevW-1:0] * drb[dtcc_pkg::DevW-1:0];
        tmpl_ready <= 1'b1;
      end

      if (cmd.dot_start) begin
        kk     <= '0;
        rd_idx <= hist_pos - eff_off - dtcc_pkg::HistAw'(eff_len);
        acc_a  <= '0;
        acc_b  <= '0;
        v0 <= 1'b0;
        v1 <= 1'b0;
        v2 <= 1'b0;
      end
      if (cmd.dot_run) begin
        if (rd_en) begin
          kk     <= kk + 13'd1;
          rd_idx <= rd_idx + 15'd1;
        end
        v0 <= rd_en;
        v1 <= v0;
        v2 <= v1;
        lt_a <= 29'(eff_len * tdat_a);
        lt_b <= 29'(eff_len * tdat_b);
        h1_a <= hdat_b;
        h1_b <= hdat_a;
        prod_a <= ($signed({1'b0, lt_a}) - $signed({2'b0, sum_a})) * $signed({1'b0, h1_a});
        prod_b <= ($signed({1'b0, lt_b}) - $signed({2'b0, sum_b})) * $signed({1'b0, h1_b});
        if (v2) begin
          acc_a <= acc_a + dtcc_pkg::AccW'(prod_a);
          acc_b <= acc_b + dtcc_pkg::AccW'(prod_b);
        end
      end

      if (cmd.div_init) begin
        neg_a <= acc_a[dtcc_pkg::AccW-1];
        neg_b <= acc_b[dtcc_pkg::AccW-1];
        rem_a <= dtcc_pkg::RemW'(abs_acc(acc_a));
        rem_b <= dtcc_pkg::RemW'(abs_acc(acc_b));
        sat_a <= dtcc_pkg::RemW'(abs_acc(acc_a) >> 3) >= dtcc_pkg::RemW'(norm);
        sat_b <= dtcc_pkg::RemW'(abs_acc(acc_b) >> 3) >= dtcc_pkg::RemW'(norm);
        q_a <= '0;
        q_b <= '0;
        step <= '0;
      end
      if (cmd.div_step) begin
        if (rem_a >= den4) begin
          rem_a <= (rem_a - den4) << 1;
          q_a   <= {q_a[dtcc_pkg::QW-2:0], 1'b1};
        end else begin
          rem_a <= rem_a << 1;
          q_a   <= {q_a[dtcc_pkg::QW-2:0], 1'b0};
        end
        if (rem_b >= den4) begin
          rem_b <= (rem_b - den4) << 1;
          q_b   <= {q_b[dtcc_pkg::QW-2:0], 1'b1};
        end else begin
          rem_b <= rem_b << 1;
          q_b   <= {q_b[dtcc_pkg::QW-2:0], 1'b0};
        end
        step <= step + 6'd1;
      end

      if (cmd.finish) begin
        out_valid       <= 1'b1;
        lag_from_offset <= $signed(lag);
        corr_a_on_b     <= cab;
        corr_b_on_a     <= cba;
        if (cab > $signed({1'b0, peak_a_on_b})) begin
          peak_a_on_b     <= cab[14:0];
          peak_a_on_b_lag <= $signed(lag);
        end
        if (cba > $signed({1'b0, peak_b_on_a})) begin
          peak_b_on_a     <= cba[14:0];
          peak_b_on_a_lag <= $signed(lag);
        end
      end
    end
  end

endmodule
